@@ hdl/clnw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants of the character-LCD nibble writer
// Request and command codes, status codes, bus words, the job descriptor
// passed from front to back, and the init word table.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_HOLD_US = 2'd2;

    localparam logic [5:0]  ROW_LENGTH_RST   = 6'd16;
    localparam logic [1:0]  ROW_COUNT_RST    = 2'd2;
    localparam logic [15:0] WORD_HOLD_US_RST = 16'd2000;

    // request types
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_POS  = 2'd1;
    localparam logic [1:0] REQ_CMD  = 2'd2;

    // command codes
    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_ON    = 3'd1;
    localparam logic [2:0] CMD_OFF   = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_HOME  = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_COL = 2'd1;
    localparam logic [1:0] STATUS_BAD_ROW = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

    // bus words: bit 9 RS, bit 8 RW, bits 7:0 data
    localparam logic [9:0] WORD_DATA       = 10'h200;
    localparam logic [9:0] WORD_SET_DDRAM  = 10'h080;
    localparam logic [9:0] WORD_ROW2_START = 10'h0C0;
    localparam logic [9:0] WORD_FUNC_4BIT  = 10'h020;
    localparam logic [9:0] WORD_FUNC_2LINE = 10'h028;
    localparam logic [9:0] WORD_DISP_OFF   = 10'h008;
    localparam logic [9:0] WORD_CLEAR      = 10'h001;
    localparam logic [9:0] WORD_ENTRY_MODE = 10'h006;
    localparam logic [9:0] WORD_DISP_ON    = 10'h00F;
    localparam logic [9:0] WORD_HOME       = 10'h002;

    // timing
    localparam logic [15:0] NIBBLE_HOLD_US = 16'd1;
    localparam logic [15:0] INIT_PAUSE_US  = 16'd60000;
    localparam logic [16:0] INIT_EXTRA_US  = 17'd8000;

    // beat sequencing of the back end
    localparam int          STEP_W         = 5;
    localparam logic [4:0]  INIT_LAST_STEP = 5'd16;
    localparam logic [4:0]  WORD_LAST_ONE  = 5'd1;
    localparam logic [4:0]  WORD_LAST_TWO  = 5'd3;

    typedef enum logic [1:0] {
        JOB_STATUS,
        JOB_WORD,
        JOB_INIT
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [1:0] status;
        logic       two_words;
        logic [9:0] word0;
        logic [9:0] word1;
    } job_t;

    function automatic logic [9:0] init_word(input logic [2:0] idx);
        logic [9:0] w;
        unique case (idx)
            3'd0:    w = WORD_FUNC_4BIT;
            3'd1:    w = WORD_FUNC_4BIT;
            3'd2:    w = WORD_FUNC_4BIT;
            3'd3:    w = WORD_FUNC_2LINE;
            3'd4:    w = WORD_DISP_OFF;
            3'd5:    w = WORD_CLEAR;
            3'd6:    w = WORD_ENTRY_MODE;
            default: w = WORD_DISP_ON;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ hdl/clnw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_if: request and result channels
// Valid/ready channels carrying one request or one bus result per beat.
// ----------------------------------------------------------------------------
interface clnw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
    logic [2:0] cmd_code;

    modport source (output valid, req_type, char_code, column, row, cmd_code,
                    input ready);
    modport sink   (input valid, req_type, char_code, column, row, cmd_code,
                    output ready);
endinterface

interface clnw_res_if;
    logic        valid;
    logic        ready;
    logic        strobe_res;
    logic        reg_select;
    logic        read_write;
    logic [3:0]  nibble;
    logic [15:0] hold_us;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, strobe_res, reg_select, read_write, nibble,
                    hold_us, status, last, input ready);
    modport sink   (input valid, strobe_res, reg_select, read_write, nibble,
                    hold_us, status, last, output ready);
endinterface
`default_nettype wire

@@ hdl/clnw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_front: request decoder
// Accepts requests, checks them, keeps the string character count and
// turns each request into one job for the back end.
// ----------------------------------------------------------------------------
module clnw_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    clnw_req_if.sink           req,
    input  wire logic [5:0]    row_length,
    input  wire logic [1:0]    row_count,
    input  wire logic          queue_full,
    output logic               push,
    output clnw_pkg::job_t     job
);

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] char_inc;

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;
    assign char_inc  = count_reg + 8'd1;

    always_comb
    begin
        job            = '0;
        job.kind       = clnw_pkg::JOB_STATUS;
        job.status     = clnw_pkg::STATUS_OK;
        count_next     = count_reg;
        unique case (req.req_type)
            clnw_pkg::REQ_CHAR:
            begin
                if (req.char_code == 8'd0)
                begin
                    count_next = 8'd0;
                end
                else
                begin
                    count_next    = char_inc;
                    job.kind      = clnw_pkg::JOB_WORD;
                    job.word0     = clnw_pkg::WORD_DATA | {2'b00, req.char_code};
                    job.word1     = clnw_pkg::WORD_ROW2_START;
                    // wrap to row two once the row is full
                    job.two_words = (char_inc == {2'b00, row_length})
                                    && (row_count >= 2'd2);
                end
            end
            clnw_pkg::REQ_POS:
            begin
                if (req.column >= row_length)
                    job.status = clnw_pkg::STATUS_BAD_COL;
                else if (req.row >= row_count)
                    job.status = clnw_pkg::STATUS_BAD_ROW;
                else
                begin
                    job.kind  = clnw_pkg::JOB_WORD;
                    // 7-bit address: row 2 aliases onto row 0
                    job.word0 = clnw_pkg::WORD_SET_DDRAM
                                | {3'b000, req.row[0], req.column};
                end
            end
            clnw_pkg::REQ_CMD:
            begin
                job.kind = clnw_pkg::JOB_WORD;
                unique case (req.cmd_code)
                    clnw_pkg::CMD_INIT:  job.kind  = clnw_pkg::JOB_INIT;
                    clnw_pkg::CMD_ON:    job.word0 = clnw_pkg::WORD_DISP_ON;
                    clnw_pkg::CMD_OFF:   job.word0 = clnw_pkg::WORD_DISP_OFF;
                    clnw_pkg::CMD_CLEAR: job.word0 = clnw_pkg::WORD_CLEAR;
                    clnw_pkg::CMD_HOME:  job.word0 = clnw_pkg::WORD_HOME;
                    default:
                    begin
                        job.kind   = clnw_pkg::JOB_STATUS;
                        job.status = clnw_pkg::STATUS_UNKNOWN;
                    end
                endcase
            end
            default:
            begin
                job.status = clnw_pkg::STATUS_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 8'd0;
        else if (push)
            count_reg <= count_next;
    end

endmodule
`default_nettype wire

@@ hdl/clnw_job_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_job_fifo: job queue
// Short first-in first-out queue of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module clnw_job_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  clnw_pkg::job_t      push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output clnw_pkg::job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    clnw_pkg::job_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/clnw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_back: nibble sequencer
// Expands the head job into result beats, one per cycle while res is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
module clnw_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  clnw_pkg::job_t     head_job,
    input  wire logic [15:0]   word_hold_us,
    output logic               pop,
    clnw_res_if.source         res
);

    logic [clnw_pkg::STEP_W-1:0] step_reg;
    logic [clnw_pkg::STEP_W-1:0] step_next;
    logic [clnw_pkg::STEP_W-1:0] init_pos;
    logic        valid_reg;
    logic        load;

    logic        beat_strobe;
    logic        beat_rs;
    logic [3:0]  beat_nibble;
    logic [15:0] beat_hold;
    logic [1:0]  beat_status;
    logic        beat_last;
    logic [9:0]  word;
    logic        lo;
    logic [16:0] long_sum;
    logic [15:0] long_hold;

    logic        strobe_reg;
    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic [15:0] hold_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    assign load      = !valid_reg || res.ready;
    assign pop       = load && head_valid && beat_last;
    assign init_pos  = step_reg - 5'd1;
    assign long_sum  = {1'b0, word_hold_us} + clnw_pkg::INIT_EXTRA_US;
    assign long_hold = long_sum[16] ? 16'hFFFF : long_sum[15:0];

    always_comb
    begin
        beat_strobe = 1'b0;
        beat_rs     = 1'b0;
        beat_nibble = 4'd0;
        beat_hold   = 16'd0;
        beat_status = clnw_pkg::STATUS_OK;
        beat_last   = 1'b0;
        word        = 10'd0;
        lo          = 1'b0;
        unique case (head_job.kind)
            clnw_pkg::JOB_STATUS:
            begin
                beat_status = head_job.status;
                beat_last   = 1'b1;
            end
            clnw_pkg::JOB_WORD:
            begin
                word        = step_reg[1] ? head_job.word1 : head_job.word0;
                lo          = step_reg[0];
                beat_strobe = 1'b1;
                beat_rs     = word[9];
                beat_nibble = lo ? word[3:0] : word[7:4];
                beat_hold   = lo ? word_hold_us : clnw_pkg::NIBBLE_HOLD_US;
                beat_last   = (step_reg == (head_job.two_words ?
                               clnw_pkg::WORD_LAST_TWO : clnw_pkg::WORD_LAST_ONE));
            end
            clnw_pkg::JOB_INIT:
            begin
                if (step_reg == '0)
                begin
                    beat_hold = clnw_pkg::INIT_PAUSE_US;
                end
                else
                begin
                    word        = clnw_pkg::init_word(init_pos[3:1]);
                    lo          = init_pos[0];
                    beat_strobe = 1'b1;
                    beat_rs     = word[9];
                    beat_nibble = lo ? word[3:0] : word[7:4];
                    if (!lo)
                        beat_hold = clnw_pkg::NIBBLE_HOLD_US;
                    else if (init_pos[3:1] == 3'd0)
                        beat_hold = long_hold;
                    else
                        beat_hold = word_hold_us;
                end
                beat_last = (step_reg == clnw_pkg::INIT_LAST_STEP);
            end
            default:
            begin
                beat_status = clnw_pkg::STATUS_UNKNOWN;
                beat_last   = 1'b1;
            end
        endcase
    end

    assign step_next = beat_last ? '0 : step_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            strobe_reg <= beat_strobe;
            rs_reg     <= beat_rs;
            nibble_reg <= beat_nibble;
            hold_reg   <= beat_hold;
            status_reg <= beat_status;
            last_reg   <= beat_last;
        end
    end

    assign res.valid      = valid_reg;
    assign res.strobe_res = strobe_reg;
    assign res.reg_select = rs_reg;
    assign res.read_write = 1'b0;
    assign res.nibble     = nibble_reg;
    assign res.hold_us    = hold_reg;
    assign res.status     = status_reg;
    assign res.last       = last_reg;

`ifndef SYNTH
    // the only beat that is neither a transfer nor final is the init pause
    a_pause_only_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.strobe_res && !res.last |-> res.hold_us == clnw_pkg::INIT_PAUSE_US)
        else $error("non-final pause beat with wrong hold");

    // an error status closes its request and sends nothing
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != clnw_pkg::STATUS_OK |-> res.last && !res.strobe_res)
        else $error("error status on a transfer or non-final beat");

    // the beat counter never runs past the longest sequence
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= clnw_pkg::INIT_LAST_STEP)
        else $error("beat counter overrun");

    // a job only leaves the queue on a beat that is loaded
    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res.valid && res.last)
        else $error("job popped without its final beat");
`endif

endmodule
`default_nettype wire

@@ hdl/char_lcd_nibble_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit character-LCD bus writer
// Turns character, cursor-position and command requests into nibble
// transfers with RS/RW and hold times, upper nibble first.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Beat
//  -------  ---  ------------  ---------------------------------------------
//  req      in   valid/ready   one request: type, char, column, row, command
//  res      out  valid/ready   one nibble transfer, pause or status result
//  cfg      in   write enable  one register write: index, data
//
//  A request is taken whenever the job queue has room; the
//  front decodes it and updates the string count at once.
//  The back emits one result beat per cycle, while res is ready, through its
//  output register: 1 beat for a status, 2 for a word, 4 for a word pair,
//  17 for init, so each request's beat count sets the sustained rate.
//  A stalled res holds its beat; the queue keeps taking requests until full.
//  Reset clears the queue, the output stage and the string count and loads
//  row_length 16, row_count 2 and word_hold_us 2000.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [clnw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [clnw_pkg::CFG_DATA_W-1:0]   cfg_data,
    clnw_req_if.sink                               req,
    clnw_res_if.source                             res
);

    // configuration registers
    logic [5:0]  row_length_reg;
    logic [1:0]  row_count_reg;
    logic [15:0] word_hold_us_reg;

    // front to queue to back
    clnw_pkg::job_t front_job;
    clnw_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           head_valid;

    // register writes; an index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= clnw_pkg::ROW_LENGTH_RST;
            row_count_reg    <= clnw_pkg::ROW_COUNT_RST;
            word_hold_us_reg <= clnw_pkg::WORD_HOLD_US_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clnw_pkg::CFG_ROW_LENGTH:   row_length_reg   <= cfg_data[5:0];
                clnw_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data[1:0];
                clnw_pkg::CFG_WORD_HOLD_US: word_hold_us_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // decode: classifies each request and keeps the string count
    clnw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    // short job queue decouples decode from the bus sequencer
    clnw_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // sequencer: walks the nibbles of the head job, one beat per cycle while res is ready
    clnw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .word_hold_us (word_hold_us_reg),
        .pop          (pop),
        .res          (res)
    );

endmodule
`default_nettype wire
